### rtl/core/copy_request_chunk_splitter_assert.svh
// Assertion macros used by the splitter sequencer.
`ifndef COPY_REQUEST_CHUNK_SPLITTER_ASSERT_SVH
`define COPY_REQUEST_CHUNK_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CRCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/crcs_pkg.sv
`default_nettype none
package crcs_pkg;

    localparam int ROW_LIMIT   = 8192;
    localparam int ROWS_LIMIT  = 2047;
    localparam int COUNT_BITS  = 26;
    localparam int MAX_CHUNKS  = 6;

    localparam int OFS_W       = 32;
    localparam int ROW_BYTES_W = 14;
    localparam int ROW_COUNT_W = 11;
    localparam int ROW_SHIFT   = $clog2(ROW_LIMIT);
    localparam int QUO_W       = (COUNT_BITS > ROW_SHIFT) ? COUNT_BITS - ROW_SHIFT : 1;
    localparam int NCHUNK_W    = $clog2(MAX_CHUNKS + 1);

    // One chunk as worked out by the shared chunk unit
    typedef struct packed {
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic [ROW_COUNT_W-1:0] row_count;
        logic                   final_chunk;
        logic [OFS_W-1:0]       next_src;
        logic [OFS_W-1:0]       next_dst;
        logic [COUNT_BITS-1:0]  next_left;
    } t_chunk;

endpackage
`default_nettype wire

### rtl/core/copy_request_chunk_splitter.sv
// A taken request is registered into the sequencer; its first chunk is then registered to the output.
// Throughput: one chunk per cycle while the output is not stalled, from a single shared chunk unit;
// a request yields at most 6 chunks with a 26-bit count, and no new request is taken meanwhile.
// Output stalls hold the chunk unit; the next request is taken once the last chunk is loaded.
// Reset: synchronous, active low; clears the sequencer state, chunk counter and output valid only.
`default_nettype none
module copy_request_chunk_splitter
    import crcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // src_offset, dst_offset, byte_count, zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // chunk_src, chunk_dst, row_bytes, row_count, pad
    output logic             m_axis_tlast    // final_chunk
);

    localparam int IN_USED  = 2 * OFS_W + COUNT_BITS;
    localparam int OUT_USED = 2 * OFS_W + ROW_BYTES_W + ROW_COUNT_W;

    logic [OFS_W-1:0]       cur_src;
    logic [OFS_W-1:0]       cur_dst;
    logic [COUNT_BITS-1:0]  cur_left;
    t_chunk                 chunk;
    logic [OFS_W-1:0]       chunk_src;
    logic [OFS_W-1:0]       chunk_dst;
    logic [ROW_BYTES_W-1:0] row_bytes;
    logic [ROW_COUNT_W-1:0] row_count;
    logic [95:IN_USED]      unused_pad;

    assign unused_pad = s_axis_tdata[95:IN_USED];

    crcs_chunk_unit u_chunk (
        .i_src   (cur_src),
        .i_dst   (cur_dst),
        .i_left  (cur_left),
        .o_chunk (chunk)
    );

    crcs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_src         (s_axis_tdata[OFS_W-1:0]),
        .i_dst         (s_axis_tdata[2*OFS_W-1:OFS_W]),
        .i_count       (s_axis_tdata[IN_USED-1:2*OFS_W]),
        .o_cur_src     (cur_src),
        .o_cur_dst     (cur_dst),
        .o_cur_left    (cur_left),
        .i_chunk       (chunk),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_chunk_src   (chunk_src),
        .o_chunk_dst   (chunk_dst),
        .o_row_bytes   (row_bytes),
        .o_row_count   (row_count),
        .o_final_chunk (m_axis_tlast)
    );

    assign m_axis_tdata = {(96 - OUT_USED)'(0), row_count, row_bytes, chunk_dst, chunk_src};

endmodule
`default_nettype wire

### rtl/core/crcs_chunk_unit.sv
`default_nettype none
module crcs_chunk_unit
    import crcs_pkg::*;
(
    input  wire logic [OFS_W-1:0]      i_src,
    input  wire logic [OFS_W-1:0]      i_dst,
    input  wire logic [COUNT_BITS-1:0] i_left,
    output t_chunk                     o_chunk
);

    logic                  small_req;
    logic [QUO_W-1:0]      full_rows;
    logic [QUO_W-1:0]      rows_capped;
    logic [COUNT_BITS-1:0] used;

    always_comb begin
        small_req   = (i_left <= COUNT_BITS'(ROW_LIMIT));
        full_rows   = QUO_W'(i_left / ROW_LIMIT);
        // cap the full rows of one chunk
        rows_capped = (full_rows > QUO_W'(ROWS_LIMIT)) ? QUO_W'(ROWS_LIMIT) : full_rows;
        used        = small_req ? i_left
                                : COUNT_BITS'(COUNT_BITS'(rows_capped) * COUNT_BITS'(ROW_LIMIT));

        o_chunk.row_bytes   = small_req ? ROW_BYTES_W'(i_left) : ROW_BYTES_W'(ROW_LIMIT);
        o_chunk.row_count   = small_req ? ROW_COUNT_W'(1) : ROW_COUNT_W'(rows_capped);
        o_chunk.final_chunk = (used == i_left);
        o_chunk.next_src    = i_src + OFS_W'(used);
        o_chunk.next_dst    = i_dst + OFS_W'(used);
        o_chunk.next_left   = i_left - used;
    end

endmodule
`default_nettype wire

### rtl/core/crcs_seq.sv
`default_nettype none
`include "copy_request_chunk_splitter_assert.svh"
module crcs_seq
    import crcs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [OFS_W-1:0]       i_src,
    input  wire logic [OFS_W-1:0]       i_dst,
    input  wire logic [COUNT_BITS-1:0]  i_count,
    output logic [OFS_W-1:0]            o_cur_src,
    output logic [OFS_W-1:0]            o_cur_dst,
    output logic [COUNT_BITS-1:0]       o_cur_left,
    input  wire t_chunk                 i_chunk,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [OFS_W-1:0]            o_chunk_src,
    output logic [OFS_W-1:0]            o_chunk_dst,
    output logic [ROW_BYTES_W-1:0]      o_row_bytes,
    output logic [ROW_COUNT_W-1:0]      o_row_count,
    output logic                        o_final_chunk
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                   r_state, n_state;
    logic [OFS_W-1:0]       r_src, n_src;
    logic [OFS_W-1:0]       r_dst, n_dst;
    logic [COUNT_BITS-1:0]  r_left, n_left;
    logic [NCHUNK_W-1:0]    r_nchunk, n_nchunk;
    logic                   r_out_valid, n_out_valid;
    logic [OFS_W-1:0]       r_out_src;
    logic [OFS_W-1:0]       r_out_dst;
    logic [ROW_BYTES_W-1:0] r_out_bytes;
    logic [ROW_COUNT_W-1:0] r_out_rows;
    logic                   r_out_final;

    logic accept;
    logic load;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign load       = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);

    assign o_cur_src  = r_src;
    assign o_cur_dst  = r_dst;
    assign o_cur_left = r_left;

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_dst       = r_dst;
        n_left      = r_left;
        n_nchunk    = r_nchunk;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_src    = i_src;
                    n_dst    = i_dst;
                    n_left   = i_count;
                    n_nchunk = '0;
                    // a zero count leaves nothing to emit
                    if (i_count != '0) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_src       = i_chunk.next_src;
                    n_dst       = i_chunk.next_dst;
                    n_left      = i_chunk.next_left;
                    n_nchunk    = r_nchunk + NCHUNK_W'(1);
                    if (i_chunk.next_left == '0 ||
                        r_nchunk == NCHUNK_W'(MAX_CHUNKS - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_nchunk    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_nchunk    <= n_nchunk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_left <= n_left;
        if (load) begin
            r_out_src   <= r_src;
            r_out_dst   <= r_dst;
            r_out_bytes <= i_chunk.row_bytes;
            r_out_rows  <= i_chunk.row_count;
            r_out_final <= i_chunk.final_chunk;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_chunk_src   = r_out_src;
    assign o_chunk_dst   = r_out_dst;
    assign o_row_bytes   = r_out_bytes;
    assign o_row_count   = r_out_rows;
    assign o_final_chunk = r_out_final;

    `CRCS_ASSERT_NOW(a_run_has_bytes, i_clk, i_rst_n,
        r_state == ST_RUN, r_left != '0, "running with no bytes left")
    `CRCS_ASSERT_NOW(a_chunk_cap, i_clk, i_rst_n,
        r_state == ST_RUN, r_nchunk < NCHUNK_W'(MAX_CHUNKS), "chunk cap exceeded")
    `CRCS_ASSERT_NEXT(a_final_ends, i_clk, i_rst_n,
        load && i_chunk.final_chunk, r_state == ST_IDLE, "final chunk did not end the request")
    `CRCS_ASSERT_NEXT(a_start_run, i_clk, i_rst_n,
        accept && i_count != '0, r_state == ST_RUN && r_left == $past(i_count),
        "request not started")

endmodule
`default_nettype wire

### tb/copy_chunk_checker.sv
module copy_chunk_checker
    import crcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [95:0] i_req_data,    // src_offset, dst_offset, byte_count, zero pad
    input  wire logic        i_chunk_valid,
    input  wire logic        i_chunk_ready,
    input  wire logic [95:0] i_chunk_data,  // chunk_src, chunk_dst, row_bytes, row_count, pad
    input  wire logic        i_chunk_last,  // final_chunk
    output int               o_mismatches,
    output int               o_outstanding
);

    localparam int DST_LSB   = OFS_W;
    localparam int COUNT_LSB = 2 * OFS_W;
    localparam int ROWS_LSB  = 2 * OFS_W + ROW_BYTES_W;

    typedef struct {
        logic [OFS_W-1:0]       src;
        logic [OFS_W-1:0]       dst;
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic [ROW_COUNT_W-1:0] row_count;
        logic                   final_chunk;
    } t_due_chunk;

    t_due_chunk chunks_due[$];

    initial o_mismatches = 0;
    initial o_outstanding = 0;

    // Work out the chunks that one copy request turns into, in order
    function automatic void split_request(input logic [OFS_W-1:0] src,
                                          input logic [OFS_W-1:0] dst,
                                          input logic [COUNT_BITS-1:0] count,
                                          ref t_due_chunk due[$]);
        logic [63:0] left;
        logic [63:0] width;
        logic [63:0] rows;
        logic [63:0] used;
        t_due_chunk  c;
        int          n;
        left = 64'(count);
        n = 0;
        while (left != 0 && n < MAX_CHUNKS) begin
            if (left <= 64'(ROW_LIMIT)) begin
                width = left;
                rows = 1;
            end else begin
                width = 64'(ROW_LIMIT);
                rows = left / 64'(ROW_LIMIT);
                if (rows > 64'(ROWS_LIMIT))
                    rows = 64'(ROWS_LIMIT);
            end
            used = width * rows;
            c.src = src;
            c.dst = dst;
            c.row_bytes = width[ROW_BYTES_W-1:0];
            c.row_count = rows[ROW_COUNT_W-1:0];
            c.final_chunk = (used == left);
            due.push_back(c);
            // advance both offsets, wrapping at 32 bits
            src = src + used[OFS_W-1:0];
            dst = dst + used[OFS_W-1:0];
            left = left - used;
            n++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_due_chunk want;
        if (i_rst_n) begin
            if (i_chunk_valid && i_chunk_ready) begin
                if (chunks_due.size() == 0) begin
                    $error("chunk with no request outstanding: src 0x%0h dst 0x%0h",
                           i_chunk_data[OFS_W-1:0], i_chunk_data[DST_LSB +: OFS_W]);
                    o_mismatches++;
                end else begin
                    want = chunks_due.pop_front();
                    check_field("chunk_src", 64'(want.src), 64'(i_chunk_data[OFS_W-1:0]));
                    check_field("chunk_dst", 64'(want.dst),
                                64'(i_chunk_data[DST_LSB +: OFS_W]));
                    check_field("row_bytes", 64'(want.row_bytes),
                                64'(i_chunk_data[COUNT_LSB +: ROW_BYTES_W]));
                    check_field("row_count", 64'(want.row_count),
                                64'(i_chunk_data[ROWS_LSB +: ROW_COUNT_W]));
                    check_field("final_chunk", 64'(want.final_chunk), 64'(i_chunk_last));
                end
            end
            // a request cannot produce a chunk in the cycle it is taken, so push after the check
            if (i_req_valid && i_req_ready)
                split_request(i_req_data[OFS_W-1:0], i_req_data[DST_LSB +: OFS_W],
                              i_req_data[COUNT_LSB +: COUNT_BITS], chunks_due);
        end
        o_outstanding <= chunks_due.size();
    end

endmodule

### tb/tb_copy_request_chunk_splitter.sv
module tb_copy_request_chunk_splitter;
    import crcs_pkg::*;

    localparam int QUIET_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 10;
    localparam int RANDOM_PER_PHASE = 71;
    localparam int BULK_BYTES       = ROW_LIMIT * ROWS_LIMIT;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // src_offset, dst_offset, byte_count, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // chunk_src, chunk_dst, row_bytes, row_count, pad
    logic        m_axis_tlast;        // final_chunk

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int mismatches;
    int outstanding;

    copy_request_chunk_splitter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    copy_chunk_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_chunk_valid (m_axis_tvalid),
        .i_chunk_ready (m_axis_tready),
        .i_chunk_data  (m_axis_tdata),
        .i_chunk_last  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [OFS_W-1:0] src, input logic [OFS_W-1:0] dst,
                                input logic [COUNT_BITS-1:0] count);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(96 - 2 * OFS_W - COUNT_BITS){1'b0}}, count, dst, src};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    function automatic logic [COUNT_BITS-1:0] pick_count();
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            0: return '0;
            1, 2, 3: return COUNT_BITS'($urandom_range(1, ROW_LIMIT));
            4: return COUNT_BITS'($urandom_range(ROW_LIMIT + 1, BULK_BYTES));
            // whole rows only
            5: return COUNT_BITS'(ROW_LIMIT * $urandom_range(1, 8191));
            // around a multiple of the full chunk
            6: return COUNT_BITS'(BULK_BYTES * $urandom_range(1, 4)
                                  + $urandom_range(0, ROW_LIMIT) - $urandom_range(0, 1));
            7: return COUNT_BITS'((1 << COUNT_BITS) - 1 - $urandom_range(0, 3 * ROW_LIMIT));
            default: return COUNT_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [OFS_W-1:0] pick_offset();
        // push some offsets close to the top so they wrap
        if ($urandom_range(3) == 0)
            return 32'hFFFF_FFFF - $urandom_range(0, 4 * ROW_LIMIT);
        return $urandom();
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 61 : 0;
            recv_stall_pct <= (phase == 0) ? 61 : (phase == 1) ? 33 : 0;
            if (phase == 0) begin
                send_request(32'h0, 32'h0, 26'd0);
                send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 26'd0);
                send_request(32'h0, 32'h0, 26'd1);
                send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 26'(ROW_LIMIT));
                send_request(32'h1234_5678, 32'h8765_4321, 26'(ROW_LIMIT - 1));
                send_request(32'hFFFF_F000, 32'h0000_0100, 26'(ROW_LIMIT + 1));
                send_request(32'h0000_0100, 32'hFFFF_E000, 26'(2 * ROW_LIMIT));
                send_request(32'hAAAA_AAAA, 32'h5555_5555, 26'(2 * ROW_LIMIT + 1));
                send_request(32'h5555_5555, 32'hAAAA_AAAA, 26'(BULK_BYTES));
                send_request(32'hFFFF_FFFF, 32'h0, 26'(BULK_BYTES + 1));
                send_request(32'h0, 32'hFFFF_FFFF, 26'(BULK_BYTES + ROW_LIMIT));
                send_request(32'hFFFF_0000, 32'h0000_FFFF, 26'(BULK_BYTES + ROW_LIMIT - 1));
                send_request(32'hFFFF_F000, 32'h0000_0010, 26'h3FF_FFFF);
                send_request(32'h0, 32'h0, 26'h3FF_FFFF);
                send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 26'h3FF_E000);
                send_request(32'hFFFF_FFFF, 32'h0, 26'h200_0000);
                send_request(32'h8000_0000, 32'h7FFF_FFFF, 26'(4 * BULK_BYTES));
            end
            repeat (RANDOM_PER_PHASE)
                send_request(pick_offset(), pick_offset(), pick_count());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/crcs_pkg.sv
rtl/core/crcs_chunk_unit.sv
rtl/core/crcs_seq.sv
rtl/core/copy_request_chunk_splitter.sv
tb/copy_chunk_checker.sv
tb/tb_copy_request_chunk_splitter.sv
